[hdl/dihp_pkg.sv]
package dihp_pkg;

    localparam int ACC_W       = 31;
    localparam int ARCHIVE_LEN = 13;
    localparam int POS_W       = 4;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
    localparam logic [7:0] CH_LPAR = 8'h28;  // '('
    localparam logic [7:0] CH_RPAR = 8'h29;  // ')'
    localparam logic [7:0] CH_D    = 8'h44;  // 'D'
    localparam logic [7:0] CH_T    = 8'h54;  // 'T'
    localparam logic [7:0] CH_0    = 8'h30;  // '0'
    localparam logic [7:0] CH_9    = 8'h39;  // '9'

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LT_TWICE  = 3'd1;
    localparam logic [2:0] ERR_STRAY_GT  = 3'd2;
    localparam logic [2:0] ERR_PAR_TWICE = 3'd3;
    localparam logic [2:0] ERR_STRAY_PAR = 3'd4;

    // Warning bits
    localparam int WARN_NAME = 0;
    localparam int WARN_REG  = 1;

    // Header code bits
    localparam int HC_INT  = 0;
    localparam int HC_EXT  = 1;
    localparam int HC_NAME = 2;
    localparam int HC_FIELD = 3;
    localparam int HC_ARCH = 4;

    // Lookahead modes
    localparam logic [1:0] LK_IDLE = 2'd0;
    localparam logic [1:0] LK_D    = 2'd1;
    localparam logic [1:0] LK_ARCH = 2'd2;

    // Digit run modes
    localparam logic [1:0] DM_NONE  = 2'd0;
    localparam logic [1:0] DM_INT   = 2'd1;
    localparam logic [1:0] DM_FIELD = 2'd2;

    localparam int TEXT_NAME = 0;
    localparam int TEXT_REG  = 1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic             text_valid;
        logic             text_dest;
        logic [7:0]       text_char;
        logic             done_res;
        logic [2:0]       error_code;
        logic [1:0]       warnings;
        logic [4:0]       header_code;
        logic [ACC_W-1:0] internal_number;
        logic [ACC_W-1:0] field_number;
    } t_out_beat;

    // Character expected at each position of "FROM ARCHIVES"
    function automatic logic [7:0] archive_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h46;  // F
            4'd1:    c = 8'h52;  // R
            4'd2:    c = 8'h4F;  // O
            4'd3:    c = 8'h4D;  // M
            4'd4:    c = 8'h20;  // space
            4'd5:    c = 8'h41;  // A
            4'd6:    c = 8'h52;  // R
            4'd7:    c = 8'h43;  // C
            4'd8:    c = 8'h48;  // H
            4'd9:    c = 8'h49;  // I
            4'd10:   c = 8'h56;  // V
            4'd11:   c = 8'h45;  // E
            4'd12:   c = 8'h53;  // S
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // acc * 10 + d, clamped to ACC_MAX
    function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0]       d);
        logic [ACC_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
        return (v > {4'b0000, ACC_MAX}) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

endpackage

[hdl/dihp_stream_if.sv]
interface dihp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/data_item_header_parser.sv]
// Channel  Dir  Payload                                     Beat accepted when
// i_in     in   ch[7:0], last                               valid && ready
// o_out    out  text_valid, text_dest, text_char[7:0],      valid && ready
//               done_res, error_code[2:0], warnings[1:0],
//               header_code[4:0], internal_number[30:0],
//               field_number[30:0]
//
// One result beat per input beat; the input register hands each accepted beat to
// the result register, whose valid drives o_out.valid.
// Sustained rate is one beat per cycle while o_out is ready: the parse step (flag
// updates and one saturating multiply-by-ten accumulate) fits between the input
// register and the result register.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// parser to the line-start state; the last character of a line does the same.
// A stall on o_out holds the result register; the input register keeps
// taking a beat while it is empty, then holds until the result moves on.
module data_item_header_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dihp_stream_if.sink   i_in,
    dihp_stream_if.source o_out
);
    import dihp_pkg::*;

    // Input register
    t_in_beat  r_in;
    logic      r_in_valid;

    // Result register
    t_out_beat r_out;
    logic      r_out_valid;

    t_out_beat w_res;
    logic      w_adv;      // parse the held beat and load the result register
    logic      w_in_take;

    // Advance when the result register is empty or its beat leaves now
    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in.data;
        end
    end

    dihp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_beat  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("held input beat lost or overwritten");

    a_text_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.text_valid |-> !r_out.text_dest && (r_out.text_char == 8'h00))
        else $error("text fields set without text_valid");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |->
            (r_out.error_code == ERR_NONE) && (r_out.warnings == 2'b00) &&
            (r_out.header_code == 5'b00000) && (r_out.internal_number == '0) &&
            (r_out.field_number == '0))
        else $error("summary fields set without done_res");

endmodule

[hdl/dihp_core.sv]
module dihp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  dihp_pkg::t_in_beat  i_beat,
    output dihp_pkg::t_out_beat o_res
);
    import dihp_pkg::*;

    logic             r_past_first, n_past_first;
    logic             r_in_name, n_in_name;
    logic             r_in_reg, n_in_reg;
    logic             r_name_seen, n_name_seen;
    logic             r_reg_seen, n_reg_seen;
    logic [1:0]       r_look, n_look;
    logic [1:0]       r_digit, n_digit;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [ACC_W-1:0] r_int_acc, n_int_acc;
    logic [ACC_W-1:0] r_fld_acc, n_fld_acc;
    logic [4:0]       r_flags, n_flags;
    logic [2:0]       r_error, n_error;
    logic [1:0]       r_warn, n_warn;

    logic       w_is_digit;
    logic       w_normal;
    logic [7:0] w_ch;
    logic       w_last;

    assign w_ch       = i_beat.ch;
    assign w_last     = i_beat.last;
    assign w_is_digit = (w_ch >= CH_0) && (w_ch <= CH_9);

    always_comb begin
        n_past_first = r_past_first;
        n_in_name    = r_in_name;
        n_in_reg     = r_in_reg;
        n_name_seen  = r_name_seen;
        n_reg_seen   = r_reg_seen;
        n_look       = r_look;
        n_digit      = r_digit;
        n_pos        = r_pos;
        n_int_acc    = r_int_acc;
        n_fld_acc    = r_fld_acc;
        n_flags      = r_flags;
        n_error      = r_error;
        n_warn       = r_warn;
        w_normal     = 1'b0;
        o_res        = '0;

        if (!r_past_first) begin
            n_past_first = 1'b1;
        end else if (r_error == ERR_NONE) begin
            if (r_digit != DM_NONE) begin
                if (w_is_digit) begin
                    if (r_digit == DM_INT) begin
                        n_int_acc = acc_digit(r_int_acc, w_ch[3:0]);
                    end else begin
                        n_fld_acc = acc_digit(r_fld_acc, w_ch[3:0]);
                    end
                end else begin
                    n_digit  = DM_NONE;
                    w_normal = 1'b1;
                end
            end else if (r_look == LK_D) begin
                n_look = LK_IDLE;
                if (w_ch == CH_T && !w_last) begin
                    n_fld_acc          = '0;
                    n_flags[HC_FIELD]  = 1'b1;
                    n_digit            = DM_FIELD;
                end else begin
                    w_normal = 1'b1;
                end
            end else if (r_look == LK_ARCH) begin
                if (w_ch == archive_char(r_pos)) begin
                    if (r_pos == POS_W'(ARCHIVE_LEN - 1)) begin
                        n_flags[HC_ARCH] = 1'b1;
                        n_look           = LK_IDLE;
                        n_pos            = '0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end else begin
                    n_look   = LK_IDLE;
                    n_pos    = '0;
                    w_normal = 1'b1;
                end
            end else begin
                w_normal = 1'b1;
            end
        end

        if (w_normal) begin
            if (w_ch == CH_LT) begin
                if (r_name_seen) n_warn[WARN_NAME] = 1'b1;
                if (r_in_name) begin
                    n_error = ERR_LT_TWICE;
                end else begin
                    n_in_name        = 1'b1;
                    n_flags[HC_NAME] = 1'b1;
                end
            end else if (w_ch == CH_GT) begin
                if (!r_in_name) begin
                    n_error = ERR_STRAY_GT;
                end else begin
                    n_in_name   = 1'b0;
                    n_name_seen = 1'b1;
                end
            end else if (w_ch == CH_LPAR) begin
                if (r_reg_seen) n_warn[WARN_REG] = 1'b1;
                if (r_in_reg) begin
                    n_error = ERR_PAR_TWICE;
                end else begin
                    n_in_reg        = 1'b1;
                    n_flags[HC_EXT] = 1'b1;
                end
            end else if (w_ch == CH_RPAR) begin
                if (!r_in_reg) begin
                    n_error = ERR_STRAY_PAR;
                end else begin
                    n_in_reg   = 1'b0;
                    n_reg_seen = 1'b1;
                end
            end else if (!r_in_name && !r_in_reg) begin
                if (w_ch == CH_D && !w_last) begin
                    n_look = LK_D;
                end else if (w_ch == archive_char('0) && !w_last) begin
                    n_look = LK_ARCH;
                    n_pos  = POS_W'(1);
                end else if (w_is_digit) begin
                    n_int_acc       = {{(ACC_W-4){1'b0}}, w_ch[3:0]};
                    n_digit         = DM_INT;
                    n_flags[HC_INT] = 1'b1;
                end
            end else begin
                o_res.text_valid = 1'b1;
                o_res.text_dest  = r_in_name ? 1'(TEXT_NAME) : 1'(TEXT_REG);
                o_res.text_char  = w_ch;
            end
        end

        if (w_last) begin
            o_res.done_res        = 1'b1;
            o_res.error_code      = n_error;
            o_res.warnings        = n_warn;
            o_res.header_code     = n_flags;
            o_res.internal_number = n_int_acc;
            o_res.field_number    = n_fld_acc;
        end
    end

    // Return to the line-start state after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && w_last)) begin
            r_past_first <= 1'b0;
            r_in_name    <= 1'b0;
            r_in_reg     <= 1'b0;
            r_name_seen  <= 1'b0;
            r_reg_seen   <= 1'b0;
            r_look       <= LK_IDLE;
            r_digit      <= DM_NONE;
            r_pos        <= '0;
            r_int_acc    <= '0;
            r_fld_acc    <= '0;
            r_flags      <= '0;
            r_error      <= ERR_NONE;
            r_warn       <= '0;
        end else if (i_step) begin
            r_past_first <= n_past_first;
            r_in_name    <= n_in_name;
            r_in_reg     <= n_in_reg;
            r_name_seen  <= n_name_seen;
            r_reg_seen   <= n_reg_seen;
            r_look       <= n_look;
            r_digit      <= n_digit;
            r_pos        <= n_pos;
            r_int_acc    <= n_int_acc;
            r_fld_acc    <= n_fld_acc;
            r_flags      <= n_flags;
            r_error      <= n_error;
            r_warn       <= n_warn;
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ERR_NONE) && !(i_step && w_last) |=> r_error == $past(r_error))
        else $error("latched error changed inside a line");

    a_name_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_name |-> r_flags[HC_NAME])
        else $error("open name without name flag");

    a_match_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_look == LK_ARCH) |-> (r_pos != '0) && (r_pos < POS_W'(ARCHIVE_LEN)))
        else $error("archive match position out of range");

endmodule

[sim/tb_data_item_header_parser.sv]
module tb_data_item_header_parser;
    import dihp_pkg::*;

    localparam int HOLD_CYCLES    = 120;   // long receiver hold-off in the first random phase
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat moved on either side
    localparam int PHASE_ITEMS    = 365;   // four phases, at least 1460 characters in all
    localparam logic [8*ARCHIVE_LEN-1:0] ARCH_WORD = "FROM ARCHIVES";

    // Token shapes used to build random header lines
    typedef enum int {
        TK_NAME, TK_REG, TK_NEST, TK_DT, TK_RUN, TK_ARCH, TK_ARCH_PART, TK_D_OTHER, TK_NOISE
    } t_token_kind;

    // One row of the directed table; when pinned, want replaces the predicted beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       pinned;
        t_out_beat  want;
    } t_stim_row;

    localparam t_out_beat NO_PIN     = '0;
    localparam t_out_beat BLANK_DONE = '{done_res: 1'b1, default: '0};
    localparam t_out_beat ARCH_DT_DONE = '{
        done_res: 1'b1, header_code: 5'((1 << HC_ARCH) | (1 << HC_FIELD)),
        field_number: 31'd7, default: '0};
    localparam t_out_beat NAME_80 = '{
        text_valid: 1'b1, text_dest: 1'(TEXT_NAME), text_char: 8'h80, default: '0};
    localparam t_out_beat STRAY_PAR_DONE = '{
        done_res: 1'b1, error_code: ERR_STRAY_PAR,
        header_code: 5'((1 << HC_EXT) | (1 << HC_NAME)), default: '0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    dihp_stream_if #(.T(t_in_beat))  in_if ();
    dihp_stream_if #(.T(t_out_beat)) out_if ();

    data_item_header_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Directed lines: a lone first character, FROM ARCHIVES then DT7, and nested
    // brackets closed in crossed order ending on a stray ')'
    t_stim_row directed_rows [25] = '{
        '{8'hFF, 1'b1, 1'b1, BLANK_DONE},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{"F", 1'b0, 1'b0, NO_PIN}, '{"R", 1'b0, 1'b0, NO_PIN},
        '{"O", 1'b0, 1'b0, NO_PIN}, '{"M", 1'b0, 1'b0, NO_PIN},
        '{" ", 1'b0, 1'b0, NO_PIN}, '{"A", 1'b0, 1'b0, NO_PIN},
        '{"R", 1'b0, 1'b0, NO_PIN}, '{"C", 1'b0, 1'b0, NO_PIN},
        '{"H", 1'b0, 1'b0, NO_PIN}, '{"I", 1'b0, 1'b0, NO_PIN},
        '{"V", 1'b0, 1'b0, NO_PIN}, '{"E", 1'b0, 1'b0, NO_PIN},
        '{"S", 1'b0, 1'b0, NO_PIN},
        '{"D", 1'b0, 1'b0, NO_PIN}, '{"T", 1'b0, 1'b0, NO_PIN},
        '{"7", 1'b1, 1'b1, ARCH_DT_DONE},
        '{"q", 1'b0, 1'b0, NO_PIN},
        '{"(", 1'b0, 1'b0, NO_PIN}, '{"<", 1'b0, 1'b0, NO_PIN},
        '{8'h80, 1'b0, 1'b1, NAME_80},
        '{")", 1'b0, 1'b0, NO_PIN}, '{">", 1'b0, 1'b0, NO_PIN},
        '{")", 1'b1, 1'b1, STRAY_PAR_DONE}
    };

    // Sideband that travels with each input beat: a typed-in result, if any
    logic      pin_on;
    t_out_beat pin_beat;

    // Line parser mirror
    logic              ln_past_first, ln_in_name, ln_in_reg, ln_name_done, ln_reg_done;
    logic [1:0]        ln_look, ln_run;
    logic [POS_W-1:0]  ln_arch_pos;
    logic [ACC_W-1:0]  ln_int_acc, ln_fld_acc;
    logic [4:0]        ln_flags;
    logic [2:0]        ln_err;
    logic [1:0]        ln_warn;
    logic              txt_valid, txt_dest;
    logic [7:0]        txt_char;

    t_out_beat   parsed_beats [$];
    logic [7:0]  line_chars [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          stall_pct;
    int          send_gap_pct = 0;
    bit          hold_trig;

    function automatic logic [7:0] arch_letter(input int p);
        return ARCH_WORD[8*(ARCHIVE_LEN-1-p) +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // acc * 10 + digit, clamped at the accumulator ceiling
    function automatic logic [ACC_W-1:0] mac10_sat(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [63:0] v;
        v = acc * 64'd10 + (c - CH_0);
        return (v > ACC_MAX) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

    function automatic void clear_line();
        ln_past_first = 1'b0; ln_in_name = 1'b0; ln_in_reg = 1'b0;
        ln_name_done = 1'b0; ln_reg_done = 1'b0;
        ln_look = LK_IDLE; ln_run = DM_NONE; ln_arch_pos = '0;
        ln_int_acc = '0; ln_fld_acc = '0;
        ln_flags = '0; ln_err = ERR_NONE; ln_warn = '0;
    endfunction

    // Plain handling of one character: brackets, text, or the start of a keyword/number
    function automatic void take_plain(input logic [7:0] c, input logic l);
        case (c)
            CH_LT: begin
                if (ln_name_done) ln_warn[WARN_NAME] = 1'b1;
                if (ln_in_name) ln_err = ERR_LT_TWICE;
                else begin
                    ln_in_name = 1'b1;
                    ln_flags[HC_NAME] = 1'b1;
                end
            end
            CH_GT: begin
                if (!ln_in_name) ln_err = ERR_STRAY_GT;
                else begin
                    ln_in_name = 1'b0;
                    ln_name_done = 1'b1;
                end
            end
            CH_LPAR: begin
                if (ln_reg_done) ln_warn[WARN_REG] = 1'b1;
                if (ln_in_reg) ln_err = ERR_PAR_TWICE;
                else begin
                    ln_in_reg = 1'b1;
                    ln_flags[HC_EXT] = 1'b1;
                end
            end
            CH_RPAR: begin
                if (!ln_in_reg) ln_err = ERR_STRAY_PAR;
                else begin
                    ln_in_reg = 1'b0;
                    ln_reg_done = 1'b1;
                end
            end
            default: begin
                if (!ln_in_name && !ln_in_reg) begin
                    if (c == CH_D && !l) begin
                        ln_look = LK_D;
                    end else if (c == arch_letter(0) && !l) begin
                        ln_look = LK_ARCH;
                        ln_arch_pos = POS_W'(1);
                    end else if (is_digit(c)) begin
                        ln_int_acc = ACC_W'(c - CH_0);
                        ln_run = DM_INT;
                        ln_flags[HC_INT] = 1'b1;
                    end
                end else begin
                    txt_valid = 1'b1;
                    txt_dest = ln_in_name ? 1'(TEXT_NAME) : 1'(TEXT_REG);
                    txt_char = c;
                end
            end
        endcase
    endfunction

    // Result beat caused by one accepted character
    function automatic t_out_beat parse_char(input logic [7:0] c, input logic l);
        t_out_beat r;
        r = '0;
        txt_valid = 1'b0; txt_dest = 1'b0; txt_char = '0;
        if (!ln_past_first) begin
            ln_past_first = 1'b1;
        end else if (ln_err == ERR_NONE) begin
            if (ln_run != DM_NONE) begin
                if (is_digit(c)) begin
                    if (ln_run == DM_INT) ln_int_acc = mac10_sat(ln_int_acc, c);
                    else ln_fld_acc = mac10_sat(ln_fld_acc, c);
                end else begin
                    ln_run = DM_NONE;
                    take_plain(c, l);
                end
            end else if (ln_look == LK_D) begin
                ln_look = LK_IDLE;
                if (c == CH_T && !l) begin
                    ln_fld_acc = '0;
                    ln_flags[HC_FIELD] = 1'b1;
                    ln_run = DM_FIELD;
                end else begin
                    take_plain(c, l);
                end
            end else if (ln_look == LK_ARCH) begin
                if (ln_arch_pos < ARCHIVE_LEN && c == arch_letter(ln_arch_pos)) begin
                    ln_arch_pos = ln_arch_pos + 1'b1;
                    if (ln_arch_pos >= ARCHIVE_LEN) begin
                        ln_flags[HC_ARCH] = 1'b1;
                        ln_look = LK_IDLE;
                        ln_arch_pos = '0;
                    end
                end else begin
                    ln_look = LK_IDLE;
                    ln_arch_pos = '0;
                    take_plain(c, l);
                end
            end else begin
                take_plain(c, l);
            end
        end
        r.text_valid = txt_valid;
        r.text_dest  = txt_dest;
        r.text_char  = txt_char;
        if (l) begin
            r.done_res        = 1'b1;
            r.error_code      = ln_err;
            r.warnings        = ln_warn;
            r.header_code     = ln_flags;
            r.internal_number = ln_int_acc;
            r.field_number    = ln_fld_acc;
            clear_line();
        end
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
            mismatches++;
        end
    endfunction

    // Predict on every accepted input beat; check every accepted output beat
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            clear_line();
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (parsed_beats.size() == 0) begin
                    $display("%0t: result beat with none outstanding, expected none, got %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = parsed_beats.pop_front();
                    check_field("text_valid", want.text_valid, got.text_valid);
                    check_field("text_dest", want.text_dest, got.text_dest);
                    check_field("text_char", want.text_char, got.text_char);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("warnings", want.warnings, got.warnings);
                    check_field("header_code", want.header_code, got.header_code);
                    check_field("internal_number", want.internal_number, got.internal_number);
                    check_field("field_number", want.field_number, got.field_number);
                end
            end
            if (in_if.valid && in_if.ready) begin
                want = parse_char(in_if.data.ch, in_if.data.last);
                parsed_beats.insert(parsed_beats.size(), pin_on ? pin_beat : want);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off requested by toggling hold_trig
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Bail out when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("data_item_header_parser verification failed");
            $finish;
        end
    end

    // Offer one character; return at the edge that accepts it. Called at a clock
    // edge, so each call makes exactly one decision about valid per edge.
    task automatic push_char(input logic [7:0] c, input logic l,
                             input logic pinned, input t_out_beat want);
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= '{ch: c, last: l};
        pin_on      <= pinned;
        pin_beat    <= want;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Append one character to the line being built
    function automatic void add_char(input logic [7:0] c);
        line_chars.insert(line_chars.size(), c);
    endfunction

    function automatic void add_text(input int n);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(255)));
    endfunction

    function automatic void add_digits(input int n);
        bit nines;
        nines = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++)
            add_char(nines ? CH_9 : 8'(CH_0 + $urandom_range(9)));
    endfunction

    // Build one header line: mostly well-formed tokens, some noise, and now and
    // then a stray bracket dropped in to break it
    function automatic void compose_line();
        int          n_tok;
        int          cut;
        t_token_kind kind;
        logic [7:0]  brk;
        line_chars.delete();
        add_char(8'($urandom_range(255)));
        n_tok = $urandom_range(6);
        for (int t = 0; t < n_tok; t++) begin
            kind = t_token_kind'($urandom_range(TK_NOISE));
            if ($urandom_range(3) == 0) kind = TK_NAME;
            case (kind)
                TK_NAME: begin
                    add_char(CH_LT);
                    add_text($urandom_range(5));
                    add_char(CH_GT);
                end
                TK_REG: begin
                    add_char(CH_LPAR);
                    add_text($urandom_range(5));
                    add_char(CH_RPAR);
                end
                TK_NEST: begin
                    add_char(CH_LPAR);
                    add_char(CH_LT);
                    add_text($urandom_range(3));
                    add_char(CH_RPAR);
                    add_char(CH_GT);
                end
                TK_DT: begin
                    add_char(CH_D);
                    add_char(CH_T);
                    add_digits($urandom_range(12));
                end
                TK_RUN: add_digits($urandom_range(1, 12));
                TK_ARCH: begin
                    for (int p = 0; p < ARCHIVE_LEN; p++) add_char(arch_letter(p));
                end
                TK_ARCH_PART: begin
                    cut = $urandom_range(1, ARCHIVE_LEN - 1);
                    for (int p = 0; p < cut; p++) add_char(arch_letter(p));
                    add_char(8'($urandom_range(255)));
                end
                TK_D_OTHER: begin
                    add_char(CH_D);
                    add_char(8'($urandom_range(255)));
                end
                default: add_char(8'($urandom_range(255)));
            endcase
            if ($urandom_range(1)) add_char(8'h20);
        end
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0:       brk = CH_LT;
                1:       brk = CH_GT;
                2:       brk = CH_LPAR;
                default: brk = CH_RPAR;
            endcase
            line_chars.insert($urandom_range(1, line_chars.size()), brk);
        end
    endfunction

    initial begin
        int gap_by_phase [4];
        int stall_by_phase [4];
        int sent;
        gap_by_phase   = '{0, 46, 0, 25};
        stall_by_phase = '{0, 0, 46, 25};
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        pin_on       <= 1'b0;
        pin_beat     <= '0;
        stall_pct    <= 0;
        hold_trig    <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with both sides running flat out
        foreach (directed_rows[r])
            push_char(directed_rows[r].ch, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].want);

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = gap_by_phase[ph];
            stall_pct   <= stall_by_phase[ph];
            // First phase: hold the receiver off while the sender keeps pushing,
            // so both stages fill and input ready drops
            if (ph == 0) hold_trig <= ~hold_trig;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                compose_line();
                foreach (line_chars[k])
                    push_char(line_chars[k], k == line_chars.size() - 1, 1'b0, NO_PIN);
                sent += line_chars.size();
            end
            // Drop valid and drain before the next phase
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while (parsed_beats.size() != 0);
        end

        // Let any stray late beat show up before the verdict
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("data_item_header_parser verification clean");
        else
            $display("data_item_header_parser verification failed");
        $finish;
    end

endmodule
